// File: src/bsa_pkg.sv
// Shared constants for the block striping allocator: defaults, field widths,
// status, placement and configuration register codes.
// No dependencies; the allocator top and the testbench files refer to it by scoped names.
package bsa_pkg;

    localparam int DEF_MAX_FILES  = 8;
    localparam int DEF_MAX_BLOCKS = 1024;

    // Blocks per group in the grouped placement mode.
    localparam int GROUP_LEN = 6;

    localparam int STATUS_W = 2;
    localparam int BLOCK_W  = 10;
    localparam int FILE_W   = 3;
    localparam int OFFSET_W = 26;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd2;

    localparam logic [1:0] MODE_ROUND_ROBIN = 2'd0;
    localparam logic [1:0] MODE_SINGLE      = 2'd1;
    localparam logic [1:0] MODE_GROUPED     = 2'd2;

    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_PLACEMENT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_COUNT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES    = 2'd2;

    localparam logic [1:0]            RST_PLACEMENT_MODE = 2'd0;
    localparam logic [3:0]            RST_FILE_COUNT     = 4'd8;
    localparam logic [CFG_DATA_W-1:0] RST_BLOCK_BYTES    = 17'd4096;

endpackage

// File: src/block_striping_allocator.sv
// Block striping allocator top level: sequencer, counters, offset multiplier.
// From start to done: a lookup's table read returns in S_RD; a single-file create
// passes S_MUL and S_FIN; round-robin and grouped creates first wait in S_DIV_B on
// the divider; full-table and unallocated beats register at accept. One request at
// a time: busy stays high until the result is registered, so the next start is
// taken at the edge that ends the done beat. Reset clears all counters.
module block_striping_allocator #(
    parameter int MAX_FILES  = bsa_pkg::DEF_MAX_FILES,
    parameter int MAX_BLOCKS = bsa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [bsa_pkg::BLOCK_W-1:0]         block_number,
    output logic                                done,
    output logic [bsa_pkg::STATUS_W-1:0]        status,
    output logic [bsa_pkg::BLOCK_W-1:0]         result_block,
    output logic [bsa_pkg::FILE_W-1:0]          file_index,
    output logic [bsa_pkg::OFFSET_W-1:0]        byte_offset
);

    // Counter width covers the value MAX_BLOCKS itself (the full mark).
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int FIDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int NF_W   = $clog2(MAX_FILES + 1);
    // The divisor is the active file count.
    localparam int DVS_W  = NF_W;
    localparam int POS_W  = $clog2(bsa_pkg::GROUP_LEN);
    localparam int PROD_W = CNT_W + bsa_pkg::CFG_DATA_W;
    localparam int ENTRY_W = FIDX_W + bsa_pkg::OFFSET_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_B = 3'd2;  // modulo by the active file count
    localparam logic [2:0] S_MUL   = 3'd3;  // block count times block size
    localparam logic [2:0] S_FIN   = 3'd4;  // saturate, store, advance counters
    localparam logic [2:0] S_RD    = 3'd5;  // table read data is back

    // Configuration registers.
    logic [1:0]                       mode_reg;
    logic [3:0]                       file_count_reg;
    logic [bsa_pkg::CFG_DATA_W-1:0]   block_bytes_reg;

    // Allocation state.
    logic [2:0]                       state_reg;
    logic [CNT_W-1:0]                 next_block_reg;
    logic [CNT_W-1:0]                 group_reg;
    logic [POS_W-1:0]                 group_pos_reg;
    logic [CNT_W-1:0]                 per_file_reg [MAX_FILES];
    logic [FIDX_W-1:0]                file_reg;
    logic [PROD_W-1:0]                product_reg;
    logic [bsa_pkg::BLOCK_W-1:0]      lookup_blk_reg;

    // Result beat registers.
    logic                             done_reg;
    logic [bsa_pkg::STATUS_W-1:0]     status_reg;
    logic [bsa_pkg::BLOCK_W-1:0]      result_block_reg;
    logic [bsa_pkg::FILE_W-1:0]       file_index_reg;
    logic [bsa_pkg::OFFSET_W-1:0]     byte_offset_reg;

    logic                             accept;
    logic                             is_full;
    logic                             lookup_miss;
    logic [NF_W-1:0]                  active_files;
    logic [bsa_pkg::OFFSET_W-1:0]     offset_sat;

    logic                             div_start;
    logic [CNT_W-1:0]                 div_dividend;
    logic [DVS_W-1:0]                 div_divisor;
    logic                             div_done;
    logic [DVS_W-1:0]                 div_remainder;

    logic                             tbl_wr_en;
    logic [ENTRY_W-1:0]               tbl_wr_data;
    logic                             tbl_rd_en;
    logic [ENTRY_W-1:0]               tbl_rd_data;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // A file count of zero means one file; anything above the build limit
    // is clamped to that limit.
    always_comb
    begin
        if (file_count_reg == 4'd0)
        begin
            active_files = NF_W'(1);
        end
        else if (file_count_reg > MAX_FILES)
        begin
            active_files = NF_W'(MAX_FILES);
        end
        else
        begin
            active_files = NF_W'(file_count_reg);
        end
    end

    assign is_full     = (next_block_reg >= MAX_BLOCKS);
    assign lookup_miss = (block_number >= next_block_reg) || (block_number >= MAX_BLOCKS);

    // The divider is launched straight from the accept edge. The grouped mode
    // divides the group number, which is kept as a counter beside the block
    // counter, so no division by the group length is ever needed.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = next_block_reg;
        div_divisor  = DVS_W'(active_files);
        if (mode_reg == bsa_pkg::MODE_GROUPED)
        begin
            div_dividend = group_reg;
        end
        if (state_reg == S_IDLE && accept && req_type == bsa_pkg::REQ_CREATE && !is_full
            && mode_reg != bsa_pkg::MODE_SINGLE)
        begin
            div_start = 1'b1;
        end
    end

    // The offset saturates rather than wrapping when block size times the
    // file's block count runs past the offset field.
    assign offset_sat = (product_reg > bsa_pkg::OFFSET_MAX) ? bsa_pkg::OFFSET_MAX
                                                            : bsa_pkg::OFFSET_W'(product_reg);

    assign tbl_wr_en   = (state_reg == S_FIN);
    assign tbl_wr_data = {file_reg, offset_sat};
    assign tbl_rd_en   = accept && req_type == bsa_pkg::REQ_LOOKUP && !lookup_miss;

    bsa_divider #(
        .DIVIDEND_W (CNT_W),
        .DIVISOR_W  (DVS_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_remainder)
    );

    bsa_loc_table #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_loc_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (ADDR_W'(next_block_reg)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (ADDR_W'(block_number)),
        .rd_data (tbl_rd_data)
    );

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= bsa_pkg::RST_PLACEMENT_MODE;
            file_count_reg  <= bsa_pkg::RST_FILE_COUNT;
            block_bytes_reg <= bsa_pkg::RST_BLOCK_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsa_pkg::CFG_PLACEMENT_MODE: mode_reg        <= cfg_data[1:0];
                bsa_pkg::CFG_FILE_COUNT:     file_count_reg  <= cfg_data[3:0];
                bsa_pkg::CFG_BLOCK_BYTES:    block_bytes_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Sequencer and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_block_reg <= '0;
            group_reg      <= '0;
            group_pos_reg  <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < MAX_FILES; i++)
            begin
                per_file_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == bsa_pkg::REQ_CREATE)
                        begin
                            if (is_full)
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                case (mode_reg)
                                    bsa_pkg::MODE_SINGLE:  state_reg <= S_MUL;
                                    default:               state_reg <= S_DIV_B;
                                endcase
                            end
                        end
                        else if (lookup_miss)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_DIV_B:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    per_file_reg[file_reg] <= per_file_reg[file_reg] + 1'b1;
                    next_block_reg         <= next_block_reg + 1'b1;
                    // The group number is the block counter divided by the group
                    // length; the position wraps once per full group.
                    if (group_pos_reg == POS_W'(bsa_pkg::GROUP_LEN - 1))
                    begin
                        group_pos_reg <= '0;
                        group_reg     <= group_reg + 1'b1;
                    end
                    else
                    begin
                        group_pos_reg <= group_pos_reg + 1'b1;
                    end
                    done_reg               <= 1'b1;
                    state_reg              <= S_IDLE;
                end
                S_RD:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            file_reg       <= '0;
            lookup_blk_reg <= block_number;
            if (req_type == bsa_pkg::REQ_CREATE && is_full)
            begin
                status_reg       <= bsa_pkg::ST_FULL;
                result_block_reg <= '0;
                file_index_reg   <= '0;
                byte_offset_reg  <= '0;
            end
            else if (req_type == bsa_pkg::REQ_LOOKUP && lookup_miss)
            begin
                status_reg       <= bsa_pkg::ST_UNALLOC;
                result_block_reg <= block_number;
                file_index_reg   <= '0;
                byte_offset_reg  <= '0;
            end
        end
        if (state_reg == S_DIV_B && div_done)
        begin
            file_reg <= FIDX_W'(div_remainder);
        end
        if (state_reg == S_MUL)
        begin
            product_reg <= PROD_W'(per_file_reg[file_reg]) * PROD_W'(block_bytes_reg);
        end
        if (state_reg == S_FIN)
        begin
            status_reg       <= bsa_pkg::ST_OK;
            result_block_reg <= bsa_pkg::BLOCK_W'(next_block_reg);
            file_index_reg   <= bsa_pkg::FILE_W'(file_reg);
            byte_offset_reg  <= offset_sat;
        end
        if (state_reg == S_RD)
        begin
            status_reg       <= bsa_pkg::ST_OK;
            result_block_reg <= lookup_blk_reg;
            file_index_reg   <= bsa_pkg::FILE_W'(tbl_rd_data[ENTRY_W-1:bsa_pkg::OFFSET_W]);
            byte_offset_reg  <= tbl_rd_data[bsa_pkg::OFFSET_W-1:0];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_block = result_block_reg;
    assign file_index   = file_index_reg;
    assign byte_offset  = byte_offset_reg;

    // The block counter never passes the full mark.
    a_next_block_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_block_reg <= MAX_BLOCKS)
        else $error("next block counter passed the table size");

    // Finishing a create gives an ok beat and advances the counter by one.
    a_fin_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> done_reg && status_reg == bsa_pkg::ST_OK
                                 && next_block_reg == $past(next_block_reg) + 1'b1)
        else $error("create did not complete with an ok beat");

    // A full-table beat carries zero location fields.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == bsa_pkg::ST_FULL) |->
            result_block_reg == '0 && file_index_reg == '0 && byte_offset_reg == '0)
        else $error("full-table beat carries a location");

    // The divider only reports back while the sequencer waits on it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_B))
        else $error("divider finished outside a divide step");

endmodule

// File: src/bsa_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Used by the allocator for the modulo by the active file count; only the remainder
// is brought out. No package dependencies.
module bsa_divider #(
    parameter int DIVIDEND_W = 11,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  trial_ge;
    logic [DIVISOR_W:0]    trial_diff;
    logic [DIVISOR_W-1:0]  rem_next;

    // The partial remainder always stays below the divisor, so the trial
    // value fits one extra bit and the result fits the divisor width.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_ge   = (trial >= {1'b0, dvs_reg});
        trial_diff = trial - {1'b0, dvs_reg};
        rem_next   = trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: src/bsa_loc_table.sv
// Location table: one write port and one registered read port.
// Holds the file and byte offset of every allocated block; no dependencies.
module bsa_loc_table #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 29
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/block_striping_allocator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the block striping allocator: follows the register writes and request
// beats, predicts each result beat and compares it field by field. Depends on bsa_pkg.
module block_striping_allocator_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                req_type,
    input  logic [bsa_pkg::BLOCK_W-1:0]         block_number,
    input  logic                                done,
    input  logic [bsa_pkg::STATUS_W-1:0]        status,
    input  logic [bsa_pkg::BLOCK_W-1:0]         result_block,
    input  logic [bsa_pkg::FILE_W-1:0]          file_index,
    input  logic [bsa_pkg::OFFSET_W-1:0]        byte_offset,
    output int                                  failures,
    output int                                  pending
);

    localparam int FILES  = bsa_pkg::DEF_MAX_FILES;
    localparam int BLOCKS = bsa_pkg::DEF_MAX_BLOCKS;

    typedef struct packed {
        logic [bsa_pkg::STATUS_W-1:0] status;
        logic [bsa_pkg::BLOCK_W-1:0]  block;
        logic [bsa_pkg::FILE_W-1:0]   file;
        logic [bsa_pkg::OFFSET_W-1:0] offset;
    } placement_t;

    logic [1:0]                   mode_q;
    logic [3:0]                   files_q;
    logic [bsa_pkg::CFG_DATA_W-1:0] bytes_q;

    logic [10:0]                  blocks_issued;
    logic [10:0]                  file_fill [FILES];
    logic [bsa_pkg::FILE_W-1:0]   loc_file [BLOCKS];
    logic [bsa_pkg::OFFSET_W-1:0] loc_offset [BLOCKS];

    placement_t placements_due[$];

    // Works out the result of one request and advances the allocation state.
    function automatic placement_t place_or_locate(input logic req,
                                                   input logic [bsa_pkg::BLOCK_W-1:0] blk);
        placement_t res;
        int         n;
        int         f;
        int         off;
        res = '0;
        if (req == bsa_pkg::REQ_CREATE)
        begin
            if (blocks_issued >= BLOCKS)
            begin
                res.status = bsa_pkg::ST_FULL;
            end
            else
            begin
                n = int'(files_q);
                if (n == 0) n = 1;
                if (n > FILES) n = FILES;
                if (mode_q == bsa_pkg::MODE_SINGLE)
                    f = 0;
                else if (mode_q == bsa_pkg::MODE_GROUPED)
                    f = (int'(blocks_issued) / bsa_pkg::GROUP_LEN) % n;
                else
                    f = int'(blocks_issued) % n;
                off = int'(file_fill[f]) * int'(bytes_q);
                if (off > int'(bsa_pkg::OFFSET_MAX)) off = int'(bsa_pkg::OFFSET_MAX);
                loc_file[blocks_issued[9:0]]   = bsa_pkg::FILE_W'(f);
                loc_offset[blocks_issued[9:0]] = bsa_pkg::OFFSET_W'(off);
                file_fill[f] = file_fill[f] + 11'd1;
                res.status = bsa_pkg::ST_OK;
                res.block  = blocks_issued[9:0];
                res.file   = bsa_pkg::FILE_W'(f);
                res.offset = bsa_pkg::OFFSET_W'(off);
                blocks_issued = blocks_issued + 11'd1;
            end
        end
        else if (blk >= blocks_issued)
        begin
            res.status = bsa_pkg::ST_UNALLOC;
            res.block  = blk;
        end
        else
        begin
            res.status = bsa_pkg::ST_OK;
            res.block  = blk;
            res.file   = loc_file[blk];
            res.offset = loc_offset[blk];
        end
        return res;
    endfunction

    function automatic int field_mismatch(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        placement_t want;
        int         errs;
        if (!rst_n)
        begin
            mode_q        = bsa_pkg::RST_PLACEMENT_MODE;
            files_q       = bsa_pkg::RST_FILE_COUNT;
            bytes_q       = bsa_pkg::RST_BLOCK_BYTES;
            blocks_issued = '0;
            foreach (file_fill[i]) file_fill[i] = '0;
            placements_due.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            errs = 0;
            // Results are compared before this edge's request is queued.
            if (done)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding: block %0d", result_block);
                    errs++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    errs += field_mismatch("status", want.status, status);
                    errs += field_mismatch("result_block", want.block, result_block);
                    errs += field_mismatch("file_index", want.file, file_index);
                    errs += field_mismatch("byte_offset", want.offset, byte_offset);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    bsa_pkg::CFG_PLACEMENT_MODE: mode_q  = cfg_data[1:0];
                    bsa_pkg::CFG_FILE_COUNT:     files_q = cfg_data[3:0];
                    bsa_pkg::CFG_BLOCK_BYTES:    bytes_q = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                placements_due.push_back(place_or_locate(req_type, block_number));
            failures <= failures + errs;
            pending  <= placements_due.size();
        end
    end

endmodule

// File: tb/block_striping_allocator_tb.sv
`timescale 1ns / 100ps
// Top of the block striping allocator testbench: clock, reset, register writes and
// request stimulus; checking is done by block_striping_allocator_checker. Depends on bsa_pkg.
module block_striping_allocator_tb;

    // Far above the slowest correct run: about 1800 beats, each with its busy stretch
    // and the sender gaps of the sparsest phases.
    localparam int CYCLE_LIMIT = 1_000_000;
    // A create is the longest operation; wait well beyond it
    // before touching registers or ending the run.
    localparam int SETTLE_CYCLES = 32;
    localparam int BLOCKS = bsa_pkg::DEF_MAX_BLOCKS;

    // Index 3 is not a register, and placement code 3 falls back to round robin.
    localparam logic [bsa_pkg::CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [1:0]                      MODE_SPARE = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            start;
    logic                            busy;
    logic                            req_type;
    logic [bsa_pkg::BLOCK_W-1:0]     block_number;
    logic                            done;
    logic [bsa_pkg::STATUS_W-1:0]    status;
    logic [bsa_pkg::BLOCK_W-1:0]     result_block;
    logic [bsa_pkg::FILE_W-1:0]      file_index;
    logic [bsa_pkg::OFFSET_W-1:0]    byte_offset;

    int failures;
    int pending;
    int cycle_count = 0;
    // Number of create beats sent while the table still had room; this equals the
    // block counter inside the design, so lookups can be aimed at allocated blocks.
    int creates_sent;
    // Chance in percent that the sender idles for another cycle before a beat.
    int idle_pct;

    block_striping_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .block_number (block_number),
        .done         (done),
        .status       (status),
        .result_block (result_block),
        .file_index   (file_index),
        .byte_offset  (byte_offset)
    );

    block_striping_allocator_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .block_number (block_number),
        .done         (done),
        .status       (status),
        .result_block (result_block),
        .file_index   (file_index),
        .byte_offset  (byte_offset),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drives one request beat and returns at the edge that accepts it. The caller
    // may drive the next beat at that same edge, so start stays high with no dip.
    task automatic send_beat(input logic req, input logic [bsa_pkg::BLOCK_W-1:0] blk);
        start        <= 1'b1;
        req_type     <= req;
        block_number <= blk;
        do @(posedge clk); while (busy);
        if (req == bsa_pkg::REQ_CREATE && creates_sent < BLOCKS)
            creates_sent++;
    endtask

    // Random idle cycles ahead of a beat; with a geometric length, gaps land on every
    // cycle of the block's work and long runs of back-to-back beats still occur.
    task automatic sender_gap();
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every result has come back and the block has gone quiet.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write so
    // that back-to-back writes never drop and raise it in one step.
    task automatic write_reg(input logic [bsa_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bsa_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [bsa_pkg::CFG_DATA_W-1:0] mode_data,
                             input logic [bsa_pkg::CFG_DATA_W-1:0] files_data,
                             input logic [bsa_pkg::CFG_DATA_W-1:0] bytes_data);
        write_reg(bsa_pkg::CFG_PLACEMENT_MODE, mode_data);
        write_reg(bsa_pkg::CFG_FILE_COUNT, files_data);
        write_reg(bsa_pkg::CFG_BLOCK_BYTES, bytes_data);
        cfg_we <= 1'b0;
    endtask

    // Mostly creates and lookups of blocks that exist, so the table fills and the
    // stored placements are read back; a quarter of the lookups take any number.
    // Create beats carry random block numbers, which the design must ignore.
    task automatic run_phase(input int beats, input int create_pct, input int gap_pct);
        idle_pct = gap_pct;
        repeat (beats)
        begin
            sender_gap();
            if ($urandom_range(99, 0) < create_pct)
                send_beat(bsa_pkg::REQ_CREATE, bsa_pkg::BLOCK_W'($urandom));
            else if (creates_sent > 0 && $urandom_range(3, 0) != 0)
                send_beat(bsa_pkg::REQ_LOOKUP,
                          bsa_pkg::BLOCK_W'($urandom_range(creates_sent - 1, 0)));
            else
                send_beat(bsa_pkg::REQ_LOOKUP, bsa_pkg::BLOCK_W'($urandom));
        end
        quiesce();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = bsa_pkg::CFG_PLACEMENT_MODE;
        cfg_data     = '0;
        start        = 1'b0;
        req_type     = bsa_pkg::REQ_CREATE;
        block_number = '0;
        creates_sent = 0;
        idle_pct     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: lookups into an empty table, then
        // nine round-robin creates so the ninth wraps back to file 0 one block in.
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd0);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd1023);
        repeat (9) send_beat(bsa_pkg::REQ_CREATE, 10'd0);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd0);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd8);
        // One past the last allocated block must report it as not allocated.
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd9);
        quiesce();

        // A write to the unused index must change nothing. Placement code 3 acts as
        // round robin, and a file count of zero acts as a single file.
        write_reg(CFG_SPARE, '1);
        configure(bsa_pkg::CFG_DATA_W'(MODE_SPARE), 17'd0, 17'd65536);
        send_beat(bsa_pkg::REQ_CREATE, 10'h3ff);
        send_beat(bsa_pkg::REQ_CREATE, 10'h155);
        quiesce();

        // Grouped placement with a file count above the maximum, tiny blocks.
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_GROUPED), 17'd15, 17'd1);
        repeat (3) send_beat(bsa_pkg::REQ_CREATE, 10'h2aa);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd11);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd13);
        quiesce();

        // Random phases: each setting runs under one sender idling style.
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_ROUND_ROBIN), 17'd8, 17'd4096);
        run_phase(150, 50, 0);
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_SINGLE), 17'd1, 17'd1);
        run_phase(200, 80, 80);
        // Stray upper data bits must be dropped: this selects grouped mode, three files.
        configure(17'h1fffe, 17'h1fff3, 17'd65536);
        run_phase(200, 50, 33);
        configure(bsa_pkg::CFG_DATA_W'(MODE_SPARE), 17'd0, 17'd777);
        run_phase(150, 40, 0);
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_ROUND_ROBIN), 17'd15, 17'd12345);
        run_phase(150, 40, 80);
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_GROUPED), 17'd9, 17'd1);
        run_phase(150, 40, 33);
        // Block size beyond its nominal range; once file 0 holds more than 512 blocks
        // the offset no longer fits and must saturate.
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_SINGLE), 17'd1, 17'd131071);
        run_phase(450, 90, 0);
        configure(bsa_pkg::CFG_DATA_W'(bsa_pkg::MODE_GROUPED), 17'd8, 17'd65536);
        run_phase(250, 60, 80);

        // Fill whatever room is left, then creates against a full table and lookups
        // at both ends of the now fully allocated number range.
        idle_pct = 0;
        while (creates_sent < BLOCKS) send_beat(bsa_pkg::REQ_CREATE, 10'd0);
        repeat (4) send_beat(bsa_pkg::REQ_CREATE, 10'h3ff);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd0);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd1023);
        send_beat(bsa_pkg::REQ_LOOKUP, 10'd512);
        quiesce();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
